// File: hdl/lgtd_pkg.sv
// Shared types and constants for the LZW GIF/TIFF decoder.
package lgtd_pkg;

  localparam int unsigned AccW   = 32;
  localparam int unsigned HeldW  = 6;
  localparam int unsigned CodeW  = 12;
  localparam int unsigned WidthW = 4;
  localparam int unsigned IdxW   = 13;
  localparam int unsigned ByteW  = 8;

  localparam logic [WidthW-1:0] RootMin = 4'd2;
  localparam logic [WidthW-1:0] RootMax = 4'd8;
  localparam logic [HeldW-1:0]  PushLimit = 6'd24;

  typedef enum logic [2:0] {
    ST_ACCEPTED = 3'd0,
    ST_REFUSED  = 3'd1,
    ST_DATA     = 3'd2,
    ST_NEED     = 3'd3,
    ST_END      = 3'd4,
    ST_CLEAR    = 3'd5
  } status_e;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_PULL = 1'b1
  } cmd_e;

  typedef enum logic {
    REG_FORMAT = 1'b0,
    REG_START  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [CodeW-1:0] prefix;
    logic [ByteW-1:0] ch;
    logic [ByteW-1:0] first;
    logic [CodeW-1:0] len;
  } dict_entry_t;

  typedef struct packed {
    logic             en;
    logic [CodeW-1:0] addr;
  } ram_req_t;

  function automatic logic [WidthW-1:0] root_bits(logic [WidthW-1:0] sw);
    logic [WidthW-1:0] r;
    if (sw < RootMin) begin
      r = RootMin;
    end else if (sw > RootMax) begin
      r = RootMax;
    end else begin
      r = sw;
    end
    return r;
  endfunction

endpackage

// File: hdl/lzw_gif_tiff_decoder.sv
// Top level of the LZW GIF/TIFF decoder.
//
// Input stream: tuser selects push (0) or pull (1); tdata carries the
// compressed byte of a push. Output stream: one result per input transfer,
// tuser is the status, tdata holds the decoded byte and its offset in the
// string, and tlast marks the final byte (offset 0) of a string.
// A push, a pull without a full code, a clear, an end code and the first
// code after a clear need no dictionary read. A pull that continues a string
// walk makes one dictionary read. A pull that starts a new string reads the
// previous code and the new code, writes the new entry and rereads the new
// code for the walk while the table grows, and reads only the new code once
// the table is full. The single read port of the dictionary memory makes
// these steps serial. The block takes one item at a time.
// A result waits in the output register while the receiver stalls; the next
// item is taken in the cycle the waiting result is transferred.
// Reset empties the accumulator and leaves the decoder as just after a clear,
// in GIF mode with 8 root bits. The dictionary holds no data until written.
// Configuration writes also empty the accumulator and rearm the decoder.
module lzw_gif_tiff_decoder #(
  parameter int unsigned DICT_ENTRIES  = 4096,
  parameter int unsigned MAX_CODE_BITS = 12
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // in_byte
  input  logic        s_axis_tuser_i,  // cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,  // out_byte, out_pos, zero fill
  output logic [2:0]  m_axis_tuser_o,  // status
  output logic        m_axis_tlast_o,  // string_last
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [3:0]  cfg_data_i
);
  import lgtd_pkg::*;

  localparam logic [IdxW-1:0]   DictLim = IdxW'(DICT_ENTRIES);
  localparam logic [WidthW-1:0] MaxW    = WidthW'(MAX_CODE_BITS);

  typedef enum logic [2:0] {
    S_IDLE, S_LK_PREV, S_LK_CODE, S_REISSUE, S_WSTART, S_WALK
  } state_e;

  state_e            state_q, state_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [HeldW-1:0]  held_q, held_d;
  logic [WidthW-1:0] cw_q, cw_d;
  logic [IdxW-1:0]   nidx_q, nidx_d;
  logic [CodeW-1:0]  prev_q, prev_d, code_q, code_d, laddr_q, laddr_d;
  logic [CodeW-1:0]  wcode_q, wcode_d, woff_q, woff_d, plen_q, plen_d;
  logic [ByteW-1:0]  pfirst_q, pfirst_d;
  logic              after_clear_q, after_clear_d, full_q, full_d;
  logic              walking_q, walking_d, fmt_q, fmt_d;
  logic [WidthW-1:0] sw_q, sw_d;
  logic              ovalid_q, ovalid_d, olast_q, olast_d;
  status_e           ostatus_q, ostatus_d;
  logic [ByteW-1:0]  obyte_q, obyte_d;
  logic [CodeW-1:0]  opos_q, opos_d;

  ram_req_t    ram_wr, ram_rd;
  dict_entry_t ram_wdata, ram_rdata, le;

  logic [WidthW-1:0] rb;
  logic [IdxW-1:0]   clr, last_code;
  logic              slot, accept, has_code;
  logic [AccW-1:0]   mask, acc_r, acc_g, acc_e;
  logic [HeldW-1:0]  held_r, held_e, drop_n;
  logic [CodeW-1:0]  code, off;
  logic [AccW:0]     keep_r, keep_e;

  lgtd_dict_ram #(.Entries(DICT_ENTRIES)) u_ram (
    .clk_i   (clk_i),
    .wr_i    (ram_wr),
    .wdata_i (ram_wdata),
    .rd_i    (ram_rd),
    .rdata_o (ram_rdata)
  );

  assign rb        = root_bits(sw_q);
  assign clr       = IdxW'(1) << rb;
  assign last_code = fmt_q ? (IdxW'(1) << cw_q) - IdxW'(1) : IdxW'(1) << cw_q;

  always_comb begin
    if ({1'b0, laddr_q} < clr) begin
      le = '{prefix: '0, ch: laddr_q[ByteW-1:0], first: laddr_q[ByteW-1:0], len: '0};
    end else if ({1'b0, laddr_q} >= DictLim) begin
      le = '0;
    end else begin
      le = ram_rdata;
    end
  end

  always_comb begin
    mask     = (AccW'(1) << cw_q) - AccW'(1);
    has_code = held_q >= HeldW'(cw_q);
    held_r   = held_q - HeldW'(cw_q);
    keep_r   = ((AccW+1)'(1) << held_r) - (AccW+1)'(1);
    if (!fmt_q) begin
      code  = CodeW'(acc_q & mask);
      acc_r = acc_q >> cw_q;
    end else begin
      code  = CodeW'((acc_q >> held_r) & mask);
      acc_r = acc_q & keep_r[AccW-1:0];
    end
    drop_n = held_r & HeldW'(7);
    acc_g  = fmt_q ? acc_r : acc_r >> drop_n;
    held_e = held_r - drop_n;
    keep_e = ((AccW+1)'(1) << held_e) - (AccW+1)'(1);
    acc_e  = acc_g & keep_e[AccW-1:0];
  end

  assign slot   = !ovalid_q || m_axis_tready_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign off    = (state_q == S_WSTART) ? le.len : woff_q;

  always_comb begin
    state_d       = state_q;
    acc_d         = acc_q;
    held_d        = held_q;
    cw_d          = cw_q;
    nidx_d        = nidx_q;
    prev_d        = prev_q;
    code_d        = code_q;
    laddr_d       = laddr_q;
    wcode_d       = wcode_q;
    woff_d        = woff_q;
    plen_d        = plen_q;
    pfirst_d      = pfirst_q;
    after_clear_d = after_clear_q;
    full_d        = full_q;
    walking_d     = walking_q;
    fmt_d         = fmt_q;
    sw_d          = sw_q;
    ovalid_d      = ovalid_q && !m_axis_tready_i;
    ostatus_d     = ostatus_q;
    obyte_d       = obyte_q;
    opos_d        = opos_q;
    olast_d       = olast_q;
    ram_wr        = '0;
    ram_rd        = '0;
    ram_wdata     = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ovalid_d  = 1'b1;
          ostatus_d = ST_ACCEPTED;
          obyte_d   = '0;
          opos_d    = '0;
          olast_d   = 1'b0;
          if (cmd_e'(s_axis_tuser_i) == CMD_PUSH) begin
            if (held_q > PushLimit) begin
              ostatus_d = ST_REFUSED;
            end else begin
              acc_d  = fmt_q ? {acc_q[AccW-9:0], s_axis_tdata_i}
                             : acc_q | (AccW'(s_axis_tdata_i) << held_q);
              held_d = held_q + HeldW'(8);
            end
          end else if (walking_q) begin
            ovalid_d = 1'b0;
            ram_rd   = '{en: 1'b1, addr: wcode_q};
            laddr_d  = wcode_q;
            state_d  = S_WALK;
          end else if (!has_code) begin
            ostatus_d = ST_NEED;
          end else begin
            acc_d  = acc_r;
            held_d = held_r;
            if ({1'b0, code} == clr) begin
              ostatus_d     = ST_CLEAR;
              cw_d          = rb + WidthW'(1);
              nidx_d        = clr + IdxW'(2);
              after_clear_d = 1'b1;
              full_d        = 1'b0;
            end else if ({1'b0, code} == clr + IdxW'(1)) begin
              ostatus_d     = ST_END;
              acc_d         = acc_e;
              held_d        = held_e;
              cw_d          = rb + WidthW'(1);
              nidx_d        = clr + IdxW'(2);
              after_clear_d = 1'b1;
              full_d        = 1'b0;
            end else if (after_clear_q) begin
              ostatus_d     = ST_DATA;
              obyte_d       = code[ByteW-1:0];
              olast_d       = 1'b1;
              after_clear_d = 1'b0;
              prev_d        = code;
            end else if (full_q) begin
              ovalid_d = 1'b0;
              code_d   = code;
              ram_rd   = '{en: 1'b1, addr: code};
              laddr_d  = code;
              state_d  = S_WSTART;
            end else begin
              ovalid_d = 1'b0;
              code_d   = code;
              ram_rd   = '{en: 1'b1, addr: prev_q};
              laddr_d  = prev_q;
              state_d  = S_LK_PREV;
            end
          end
        end
      end
      S_LK_PREV: begin
        pfirst_d = le.first;
        plen_d   = le.len;
        ram_rd   = '{en: 1'b1, addr: code_q};
        laddr_d  = code_q;
        state_d  = S_LK_CODE;
      end
      S_LK_CODE: begin
        ram_wr    = '{en: nidx_q < DictLim, addr: nidx_q[CodeW-1:0]};
        ram_wdata = '{prefix: prev_q,
                      ch: ({1'b0, code_q} == nidx_q) ? pfirst_q : le.first,
                      first: pfirst_q,
                      len: plen_q + CodeW'(1)};
        nidx_d = nidx_q + IdxW'(1);
        if (nidx_q + IdxW'(1) == last_code) begin
          if (cw_q < MaxW) begin
            cw_d = cw_q + WidthW'(1);
          end else begin
            full_d = 1'b1;
          end
        end
        prev_d  = code_q;
        state_d = S_REISSUE;
      end
      S_REISSUE: begin
        ram_rd  = '{en: 1'b1, addr: code_q};
        laddr_d = code_q;
        state_d = S_WSTART;
      end
      S_WSTART, S_WALK: begin
        if (slot) begin
          ovalid_d  = 1'b1;
          ostatus_d = ST_DATA;
          obyte_d   = le.ch;
          opos_d    = off;
          olast_d   = (off == '0);
          walking_d = (off != '0);
          if (off != '0) begin
            wcode_d = le.prefix;
            woff_d  = off - CodeW'(1);
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      if (reg_idx_e'(cfg_idx_i) == REG_FORMAT) begin
        fmt_d = cfg_data_i[0];
      end else begin
        sw_d = cfg_data_i;
      end
      acc_d         = '0;
      held_d        = '0;
      cw_d          = root_bits(sw_d) + WidthW'(1);
      nidx_d        = (IdxW'(1) << root_bits(sw_d)) + IdxW'(2);
      after_clear_d = 1'b1;
      full_d        = 1'b0;
      walking_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      acc_q         <= '0;
      held_q        <= '0;
      cw_q          <= RootMax + WidthW'(1);
      nidx_q        <= (IdxW'(1) << RootMax) + IdxW'(2);
      prev_q        <= '0;
      wcode_q       <= '0;
      woff_q        <= '0;
      after_clear_q <= 1'b1;
      full_q        <= 1'b0;
      walking_q     <= 1'b0;
      fmt_q         <= 1'b0;
      sw_q          <= RootMax;
      ovalid_q      <= 1'b0;
    end else begin
      state_q       <= state_d;
      acc_q         <= acc_d;
      held_q        <= held_d;
      cw_q          <= cw_d;
      nidx_q        <= nidx_d;
      prev_q        <= prev_d;
      wcode_q       <= wcode_d;
      woff_q        <= woff_d;
      after_clear_q <= after_clear_d;
      full_q        <= full_d;
      walking_q     <= walking_d;
      fmt_q         <= fmt_d;
      sw_q          <= sw_d;
      ovalid_q      <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q    <= code_d;
    laddr_q   <= laddr_d;
    plen_q    <= plen_d;
    pfirst_q  <= pfirst_d;
    ostatus_q <= ostatus_d;
    obyte_q   <= obyte_d;
    opos_q    <= opos_d;
    olast_q   <= olast_d;
  end

  assign s_axis_tready_o = (state_q == S_IDLE) && slot;
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = {4'b0, opos_q, obyte_q};
  assign m_axis_tuser_o  = ostatus_q;
  assign m_axis_tlast_o  = olast_q;

  a_last_is_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tlast_o |-> m_axis_tuser_o == ST_DATA)
    else $error("tlast set on a non-data result");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(walking_q && after_clear_q))
    else $error("string walk active right after a clear");

  a_held_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= HeldW'(32))
    else $error("bit accumulator overfilled");

endmodule

// File: hdl/lgtd_dict_ram.sv
// Dictionary memory: one write port, one read port with registered read data.
module lgtd_dict_ram #(
  parameter int unsigned Entries = 4096
) (
  input  logic                 clk_i,
  input  lgtd_pkg::ram_req_t    wr_i,
  input  lgtd_pkg::dict_entry_t wdata_i,
  input  lgtd_pkg::ram_req_t    rd_i,
  output lgtd_pkg::dict_entry_t rdata_o
);
  import lgtd_pkg::*;

  localparam int unsigned AW = $clog2(Entries);

  dict_entry_t mem_q [Entries];
  dict_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[AW-1:0]] <= wdata_i;
    end
    if (rd_i.en) begin
      rdata_q <= mem_q[rd_i.addr[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the LZW GIF/TIFF decoder: directed rows, then random code streams.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lgtd_pkg::*;

  localparam int NDICT = 4096;
  localparam int MAXBITS = 12;
  localparam int WDOG_LIMIT = 3000;

  typedef struct {
    status_e     st;
    logic [7:0]  b;
    logic [11:0] pos;
    logic        last;
  } res_t;

  typedef struct {
    cmd_e       cmd;
    logic [7:0] b;
    bit         typed;
    res_t       r;
  } row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_ready;
  logic [7:0]  s_data = '0;
  logic        s_user = 1'b0;
  logic        m_valid;
  logic        m_ready = 1'b0;
  logic [23:0] m_data;
  logic [2:0]  m_user;
  logic        m_last;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = 1'b0;
  logic [3:0]  cfg_data = '0;

  lzw_gif_tiff_decoder dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Decoder state as predicted.
  dict_entry_t dict_m [NDICT];
  bit          dict_ok [NDICT];
  logic [31:0] acc;
  int          held, cw, nidx, prev_code, walk_code, walk_off;
  bit          after_clr, tab_full, walking, fmt;
  logic [3:0]  sw;

  // Encoder shadow that builds well-formed code streams.
  bit          wmap [NDICT];
  int          wcw, wnidx;
  bit          waclr, wfull;
  logic [63:0] bbuf;
  int          bn;
  logic [7:0]  stream_q [$];
  int          codes_in_flight;

  res_t        decoded_q [$];
  int          errors = 0;
  int          s_idle = 0, r_idle = 0;
  int          hold = 0;
  bit          stall_req = 1'b0;
  int          quiet = 0;

  function automatic int roots();
    if (sw < 2) return 2;
    if (sw > 8) return 8;
    return sw;
  endfunction

  function automatic int clr_code();
    return 1 << roots();
  endfunction

  function automatic int bump_at(int w);
    return fmt ? (1 << w) - 1 : (1 << w);
  endfunction

  function automatic dict_entry_t fetch(int code);
    dict_entry_t e;
    e = '0;
    if (code < clr_code()) begin
      e.ch = code[7:0];
      e.first = code[7:0];
    end else if (code < NDICT) begin
      e = dict_m[code];
    end
    return e;
  endfunction

  function automatic void rearm();
    cw = roots() + 1;
    nidx = clr_code() + 2;
    after_clr = 1'b1;
    tab_full = 1'b0;
    walking = 1'b0;
  endfunction

  function automatic res_t walk_out();
    dict_entry_t e;
    res_t r;
    e = fetch(walk_code);
    r.st = ST_DATA;
    r.b = e.ch;
    r.pos = walk_off[11:0];
    r.last = (walk_off == 0);
    if (walk_off == 0) begin
      walking = 1'b0;
    end else begin
      walk_code = e.prefix;
      walk_off = (walk_off - 1) & 12'hFFF;
    end
    return r;
  endfunction

  function automatic res_t decode(cmd_e cmd, logic [7:0] b);
    res_t r;
    int code, mask;
    dict_entry_t p, n;
    r = '{ST_ACCEPTED, 8'h00, 12'h000, 1'b0};
    if (cmd == CMD_PUSH) begin
      if (held > 24) begin
        r.st = ST_REFUSED;
        return r;
      end
      if (!fmt) acc = acc | (32'(b) << held);
      else acc = {acc[23:0], b};
      held += 8;
      return r;
    end
    if (walking) return walk_out();
    if (held < cw) begin
      r.st = ST_NEED;
      return r;
    end
    mask = (1 << cw) - 1;
    if (!fmt) begin
      code = acc & mask;
      acc = acc >> cw;
      held -= cw;
    end else begin
      code = (acc >> (held - cw)) & mask;
      held -= cw;
      acc = acc & 32'((64'd1 << held) - 1);
    end
    codes_in_flight--;
    if (code == clr_code()) begin
      rearm();
      r.st = ST_CLEAR;
      return r;
    end
    if (code == clr_code() + 1) begin
      if (!fmt) acc = acc >> (held & 7);
      held -= held & 7;
      acc = acc & 32'((64'd1 << held) - 1);
      rearm();
      r.st = ST_END;
      return r;
    end
    if (after_clr) begin
      after_clr = 1'b0;
      prev_code = code;
      r.st = ST_DATA;
      r.b = code[7:0];
      r.last = 1'b1;
      return r;
    end
    if (!tab_full) begin
      p = fetch(prev_code);
      n.prefix = prev_code[11:0];
      n.first = p.first;
      n.len = p.len + 12'd1;
      n.ch = (code == nidx) ? p.first : fetch(code).first;
      if (nidx < NDICT) begin
        dict_m[nidx] = n;
        dict_ok[nidx] = 1'b1;
      end
      nidx++;
      if (nidx == bump_at(cw)) begin
        if (cw < MAXBITS) cw++;
        else tab_full = 1'b1;
      end
      prev_code = code;
    end
    walk_code = code;
    walk_off = fetch(code).len;
    walking = 1'b1;
    return walk_out();
  endfunction

  function automatic void put_code(int c);
    codes_in_flight++;
    if (!fmt) begin
      bbuf = bbuf | (64'(c) << bn);
      bn += wcw;
      while (bn >= 8) begin
        stream_q.push_back(bbuf[7:0]);
        bbuf = bbuf >> 8;
        bn -= 8;
      end
    end else begin
      bbuf = (bbuf << wcw) | 64'(c);
      bn += wcw;
      while (bn >= 8) begin
        stream_q.push_back(8'(bbuf >> (bn - 8)));
        bn -= 8;
        bbuf = bbuf & ((64'd1 << bn) - 1);
      end
    end
    if (c == clr_code() || c == clr_code() + 1) begin
      if (c == clr_code() + 1 && bn > 0) begin
        stream_q.push_back(fmt ? 8'(bbuf << (8 - bn)) : bbuf[7:0]);
        bbuf = '0;
        bn = 0;
      end
      wcw = roots() + 1;
      wnidx = clr_code() + 2;
      waclr = 1'b1;
      wfull = 1'b0;
    end else if (waclr) begin
      waclr = 1'b0;
    end else if (!wfull) begin
      if (wnidx < NDICT) wmap[wnidx] = 1'b1;
      wnidx++;
      if (wnidx == bump_at(wcw)) begin
        if (wcw < MAXBITS) wcw++;
        else wfull = 1'b1;
      end
    end
  endfunction

  function automatic int pick_code(bit specials);
    int r, c, top;
    r = $urandom_range(99);
    top = (1 << wcw) - 1;
    if (specials && r < 2) return clr_code();
    if (specials && r < 4) return clr_code() + 1;
    if (r < 62) return $urandom_range(clr_code() - 1);
    if (r < 76 && !waclr && !wfull && wnidx < NDICT) return wnidx;
    repeat (12) begin
      c = $urandom_range(top, clr_code() + 2);
      if (wmap[c]) return c;
    end
    return $urandom_range(clr_code() - 1);
  endfunction

  task automatic offer(cmd_e cmd, logic [7:0] b, res_t r);
    decoded_q.push_back(r);
    if ($urandom_range(99) < s_idle) begin
      s_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < s_idle);
    end
    s_valid <= 1'b1;
    s_user <= cmd;
    s_data <= b;
    do @(posedge clk_i); while (!s_ready);
  endtask

  task automatic send(cmd_e cmd, logic [7:0] b);
    offer(cmd, b, decode(cmd, b));
  endtask

  task automatic settle();
    s_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(reg_idx_e idx, logic [3:0] v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == REG_FORMAT) fmt = v[0];
    else sw = v;
    acc = '0;
    held = 0;
    rearm();
  endtask

  task automatic run_phase(bit f, logic [3:0] swv, int si, int ri, int n_items,
                           bit fill, bit stall);
    int old_roots, count, r;
    bit draining;
    settle();
    old_roots = roots();
    cfg_write(REG_FORMAT, {3'b000, f});
    cfg_write(REG_START, swv);
    if (roots() != old_roots) begin
      foreach (wmap[i]) wmap[i] = 1'b0;
    end
    s_idle = si;
    r_idle = ri;
    wcw = cw;
    wnidx = nidx;
    waclr = 1'b1;
    wfull = 1'b0;
    bbuf = '0;
    bn = 0;
    stream_q.delete();
    codes_in_flight = 0;
    count = 0;
    draining = 1'b0;
    while (!draining || stream_q.size() != 0 || codes_in_flight != 0 || walking) begin
      if (!draining && count >= n_items && (!fill || wfull)) begin
        draining = 1'b1;
        put_code(clr_code() + 1);
      end
      while (!draining && stream_q.size() == 0) put_code(pick_code(!fill));
      if (stall && count == 60) stall_req = 1'b1;
      r = $urandom_range(99);
      if (held > 24) begin
        if (r < 8) send(CMD_PUSH, 8'($urandom));
        else send(CMD_PULL, 8'($urandom));
      end else if (stream_q.size() != 0 && (held < cw ? r < 90 : r < 30)) begin
        send(CMD_PUSH, stream_q.pop_front());
      end else begin
        send(CMD_PULL, 8'($urandom));
      end
      if (!fill || wfull) count++;
    end
  endtask

  row_t rows [] = '{
    '{CMD_PULL, 8'h00, 1'b1, '{ST_NEED, 8'h00, 12'h000, 1'b0}},
    '{CMD_PUSH, 8'h00, 1'b1, '{ST_ACCEPTED, 8'h00, 12'h000, 1'b0}},
    '{CMD_PUSH, 8'h01, 1'b1, '{ST_ACCEPTED, 8'h00, 12'h000, 1'b0}},
    '{CMD_PULL, 8'h00, 1'b1, '{ST_CLEAR, 8'h00, 12'h000, 1'b0}},
    '{CMD_PULL, 8'h00, 1'b1, '{ST_NEED, 8'h00, 12'h000, 1'b0}},
    '{CMD_PUSH, 8'h01, 1'b1, '{ST_ACCEPTED, 8'h00, 12'h000, 1'b0}},
    '{CMD_PULL, 8'h00, 1'b1, '{ST_DATA, 8'h80, 12'h000, 1'b1}},
    '{CMD_PUSH, 8'h00, 1'b1, '{ST_ACCEPTED, 8'h00, 12'h000, 1'b0}},
    '{CMD_PUSH, 8'h00, 1'b1, '{ST_ACCEPTED, 8'h00, 12'h000, 1'b0}},
    '{CMD_PUSH, 8'h00, 1'b1, '{ST_ACCEPTED, 8'h00, 12'h000, 1'b0}},
    '{CMD_PUSH, 8'hFF, 1'b1, '{ST_REFUSED, 8'h00, 12'h000, 1'b0}},
    '{CMD_PULL, 8'hFF, 1'b0, '{ST_ACCEPTED, 8'h00, 12'h000, 1'b0}},
    '{CMD_PULL, 8'h00, 1'b0, '{ST_ACCEPTED, 8'h00, 12'h000, 1'b0}},
    '{CMD_PULL, 8'h00, 1'b0, '{ST_ACCEPTED, 8'h00, 12'h000, 1'b0}},
    '{CMD_PULL, 8'h00, 1'b1, '{ST_NEED, 8'h00, 12'h000, 1'b0}}
  };

  initial begin
    res_t pr;
    foreach (dict_ok[i]) begin
      dict_ok[i] = 1'b0;
      wmap[i] = 1'b0;
      dict_m[i] = '0;
    end
    fmt = 1'b0;
    sw = 4'd8;
    acc = '0;
    held = 0;
    prev_code = 0;
    walk_code = 0;
    walk_off = 0;
    codes_in_flight = 0;
    rearm();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    s_idle = 22;
    r_idle = 82;
    foreach (rows[i]) begin
      pr = decode(rows[i].cmd, rows[i].b);
      offer(rows[i].cmd, rows[i].b, rows[i].typed ? rows[i].r : pr);
    end
    foreach (dict_ok[i]) wmap[i] = dict_ok[i];
    run_phase(1'b0, 4'd8, 22, 82, 300, 1'b0, 1'b0);
    run_phase(1'b1, 4'd2, 82, 22, 300, 1'b0, 1'b0);
    run_phase(1'b0, 4'd5, 0, 0, 300, 1'b0, 1'b1);
    run_phase(1'b1, 4'd15, 0, 0, 100, 1'b0, 1'b0);
    run_phase(1'b0, 4'd0, 0, 0, 100, 1'b0, 1'b0);
    run_phase(1'b1, 4'd9, 0, 0, 100, 1'b0, 1'b0);
    settle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (stall_req) begin
      stall_req = 1'b0;
      hold = 400;
    end
    if (hold > 0) begin
      hold--;
      m_ready <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= r_idle);
    end
  end

  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && m_valid && m_ready) begin
      if (decoded_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected transfer, status %0d tdata %h", $time, m_user, m_data);
      end else begin
        e = decoded_q.pop_front();
        if (m_user != e.st) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, e.st, m_user);
        end
        if (m_data[7:0] != e.b) begin
          errors++;
          $display("%0t: out_byte expected %h actual %h", $time, e.b, m_data[7:0]);
        end
        if (m_data[19:8] != e.pos) begin
          errors++;
          $display("%0t: out_pos expected %0d actual %0d", $time, e.pos, m_data[19:8]);
        end
        if (m_last != e.last) begin
          errors++;
          $display("%0t: string_last expected %0d actual %0d", $time, e.last, m_last);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_ready) || (m_valid && m_ready) || !rst_ni) begin
      quiet <= 0;
    end else if (quiet >= WDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

endmodule
